FILE: rtl/core/mm4f_pkg.sv
package mm4f_pkg;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_MUL  = 1'b1;

    localparam logic [31:0] DEFAULT_NAN = 32'hFFC00000;
    localparam logic [31:0] POS_INF     = 32'h7F800000;

    // Result of the special-case check done ahead of the main datapath.
    typedef struct packed {
        logic        hit;
        logic [31:0] value;
    } t_special;

    // Floating-point multiply, first stage output.
    typedef struct packed {
        t_special    sp;
        logic        sign;
        logic        zero;
        logic [47:0] prod;
        logic [9:0]  exp;
    } t_mul_s1;

    // Floating-point add, first stage output (aligned operands).
    typedef struct packed {
        t_special    sp;
        logic        sa;
        logic        sb;
        logic [9:0]  ea;
        logic [26:0] big;
        logic [26:0] lesser;
    } t_add_s1;

    // Common pre-rounding form: value = mant * 2^(exp - 150), exp signed.
    typedef struct packed {
        t_special    sp;
        logic        sign;
        logic        zero;
        logic [49:0] mant;
        logic [10:0] exp;
    } t_norm;

    function automatic logic f_is_nan(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic f_is_inf(input logic [31:0] a);
        return a[30:0] == POS_INF[30:0];
    endfunction

    // Position of the leading one in a 50-bit word.
    function automatic logic [5:0] f_lead(input logic [49:0] m);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 50; i++) begin
            if (m[i]) begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

    // Normalize and round mant * 2^(exp - 150) to binary32 with nearest even.
    // The mantissa has its leading one at bit lead.
    function automatic logic [31:0] f_round(input logic sign, input logic [49:0] mant,
                                            input logic signed [11:0] exp,
                                            input logic [5:0] lead);
        logic signed [12:0] e;
        logic signed [12:0] s;
        logic [74:0]        w;
        logic [74:0]        sh;
        logic [24:0]        q;
        logic               g;
        logic               st;
        logic [31:0]        bits;
        logic [32:0]        sum;
        e = 13'(signed'({1'b0, lead})) + 13'(exp) - 13'sd150 + 13'sd127;
        if (e >= 13'sd1) begin
            s = 13'(signed'({1'b0, lead})) - 13'sd23;
        end else begin
            s = 13'sd1 - 13'(exp);
        end
        w = {mant, 25'd0};
        if (s <= 13'sd0) begin
            sh = w << 6'(-s);
        end else if (s >= 13'sd70) begin
            sh = 75'd0;
            sh[0] = |mant;
        end else begin
            sh = w >> 7'(s);
            if ((w & ((75'd1 << 7'(s)) - 75'd1)) != 75'd0) begin
                sh[0] = 1'b1;
            end
        end
        q  = sh[49:25];
        g  = sh[24];
        st = |sh[23:0];
        if (g && (st || q[0])) begin
            q = q + 25'd1;
        end
        if (e >= 13'sd1) begin
            sum = {8'd0, q} + {e[7:0] - 8'd1, 23'd0};
            if (e > 13'sd254 || sum >= {1'b0, POS_INF}) begin
                bits = POS_INF;
            end else begin
                bits = sum[31:0];
            end
        end else begin
            bits = {7'd0, q};
        end
        return {sign, bits[30:0]};
    endfunction

endpackage

FILE: rtl/core/matrix4x4_float_multiply.sv
// 4x4 binary32 matrix multiply, one row per word. A load word (opcode 0) writes one
// row of the right-hand matrix and gives no result; a multiply word (opcode 1) gives
// one product row. A word is accepted every cycle while the output side keeps moving;
// a multiply row passes through nine register stages after it is accepted (three
// in the multipliers and three in each of the two chained adder levels). The whole
// pipeline advances only when its last stage can move, so a stalled output freezes it
// with nothing lost. A load takes effect for multiplies accepted after it. Rows never
// loaded read as undefined.
module matrix4x4_float_multiply (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [1:0]  i_row,
    input  logic [31:0] i_elem_a,
    input  logic [31:0] i_elem_b,
    input  logic [31:0] i_elem_c,
    input  logic [31:0] i_elem_d,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_out_row,
    output logic [31:0] o_prod_a,
    output logic [31:0] o_prod_b,
    output logic [31:0] o_prod_c,
    output logic [31:0] o_prod_d
);

    localparam int Depth = 9;

    logic [127:0]   r_rm [4];
    logic [Depth-1:0] r_vld;
    logic [1:0]     r_row [Depth];
    logic           en;
    logic           acc_mul;
    logic [31:0]    lin [4];
    logic [31:0]    mp [4][4];
    logic [31:0]    s [2][4];
    logic [31:0]    f [4];

    assign en      = !o_valid || i_ready;
    assign o_ready = en;
    assign acc_mul = i_valid && en && (i_opcode == mm4f_pkg::OP_MUL);
    assign lin     = '{i_elem_a, i_elem_b, i_elem_c, i_elem_d};

    // Right-hand matrix storage, one row per load word.
    always_ff @(posedge i_clk) begin
        if (i_valid && en && i_opcode == mm4f_pkg::OP_LOAD) begin
            r_rm[i_row] <= {i_elem_d, i_elem_c, i_elem_b, i_elem_a};
        end
    end

    // Valid and row index travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[Depth-2:0], acc_mul};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_row[0] <= i_row;
            for (int k = 1; k < Depth; k++) begin
                r_row[k] <= r_row[k-1];
            end
        end
    end

    // Sixteen multipliers, then two adder levels per column.
    for (genvar j = 0; j < 4; j++) begin : g_col
        for (genvar i = 0; i < 4; i++) begin : g_mul
            mm4f_fmul u_mul (
                .i_clk(i_clk), .i_en(en), .i_a(lin[i]),
                .i_b(r_rm[i][32*j +: 32]), .o_p(mp[i][j])
            );
        end
        mm4f_fadd u_add01 (
            .i_clk(i_clk), .i_en(en), .i_a(mp[0][j]), .i_b(mp[1][j]), .o_s(s[0][j])
        );
        mm4f_fadd u_add23 (
            .i_clk(i_clk), .i_en(en), .i_a(mp[2][j]), .i_b(mp[3][j]), .o_s(s[1][j])
        );
        mm4f_fadd u_addf (
            .i_clk(i_clk), .i_en(en), .i_a(s[0][j]), .i_b(s[1][j]), .o_s(f[j])
        );
    end

    assign o_valid   = r_vld[Depth-1];
    assign o_out_row = r_row[Depth-1];
    assign o_prod_a  = f[0];
    assign o_prod_b  = f[1];
    assign o_prod_c  = f[2];
    assign o_prod_d  = f[3];

    // A stalled result must hold its row index.
    a_hold_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_row))
        else $error("row index changed under stall");

    // Ready follows the output stage alone.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("pipeline stalled with empty output");

    // A load word never produces a result.
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_opcode == mm4f_pkg::OP_LOAD |=> !r_vld[0])
        else $error("load word entered the result pipeline");

endmodule

FILE: rtl/core/mm4f_fmul.sv
// Three-stage binary32 multiplier: decode, multiply, normalize and round.
module mm4f_fmul (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_p
);

    mm4f_pkg::t_special r_sp0;
    logic               r_sign0;
    logic               r_zero0;
    logic [23:0]        r_ma;
    logic [23:0]        r_mb;
    logic [9:0]         r_exp0;
    mm4f_pkg::t_mul_s1  r_s1;
    mm4f_pkg::t_special n_sp0;

    // Special cases and operand decode.
    always_comb begin
        n_sp0 = '0;
        if (mm4f_pkg::f_is_nan(i_a)) begin
            n_sp0 = '{1'b1, i_a | 32'h00400000};
        end else if (mm4f_pkg::f_is_nan(i_b)) begin
            n_sp0 = '{1'b1, i_b | 32'h00400000};
        end else if (mm4f_pkg::f_is_inf(i_a) || mm4f_pkg::f_is_inf(i_b)) begin
            if (i_a[30:0] == 31'd0 || i_b[30:0] == 31'd0) begin
                n_sp0 = '{1'b1, mm4f_pkg::DEFAULT_NAN};
            end else begin
                n_sp0 = '{1'b1, {i_a[31] ^ i_b[31], mm4f_pkg::POS_INF[30:0]}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sp0   <= n_sp0;
            r_sign0 <= i_a[31] ^ i_b[31];
            r_zero0 <= (i_a[30:0] == 31'd0) || (i_b[30:0] == 31'd0);
            r_ma    <= {|i_a[30:23], i_a[22:0]};
            r_mb    <= {|i_b[30:23], i_b[22:0]};
            r_exp0  <= 10'((i_a[30:23] == 8'd0) ? 8'd1 : i_a[30:23])
                     + 10'((i_b[30:23] == 8'd0) ? 8'd1 : i_b[30:23]);
        end
    end

    // Mantissa product.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1.sp   <= r_sp0;
            r_s1.sign <= r_sign0;
            r_s1.zero <= r_zero0;
            r_s1.prod <= r_ma * r_mb;
            r_s1.exp  <= r_exp0;
        end
    end

    // Round: value = prod * 2^(ea + eb - 300) = prod * 2^((exp - 150) - 150).
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_s1.sp.hit) begin
                o_p <= r_s1.sp.value;
            end else if (r_s1.zero) begin
                o_p <= {r_s1.sign, 31'd0};
            end else begin
                o_p <= mm4f_pkg::f_round(r_s1.sign, {2'd0, r_s1.prod},
                       12'(signed'({2'b0, r_s1.exp})) - 12'sd150,
                       mm4f_pkg::f_lead({2'd0, r_s1.prod}));
            end
        end
    end

endmodule

FILE: rtl/core/mm4f_fadd.sv
// Three-stage binary32 adder: align, add, normalize and round.
module mm4f_fadd (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_s
);

    mm4f_pkg::t_add_s1  r_s1;
    mm4f_pkg::t_add_s1  n_s1;
    mm4f_pkg::t_norm    r_s2;
    mm4f_pkg::t_norm    n_s2;

    // Special cases, swap and alignment with a sticky bit.
    always_comb begin
        logic [23:0] ma;
        logic [23:0] mb;
        logic [7:0]  ea;
        logic [7:0]  eb;
        logic [7:0]  d;
        logic [49:0] full;
        logic [49:0] shf;
        logic        sa;
        logic        sb;
        n_s1 = '0;
        ma = {|i_a[30:23], i_a[22:0]};
        mb = {|i_b[30:23], i_b[22:0]};
        ea = (i_a[30:23] == 8'd0) ? 8'd1 : i_a[30:23];
        eb = (i_b[30:23] == 8'd0) ? 8'd1 : i_b[30:23];
        sa = i_a[31];
        sb = i_b[31];
        if (mm4f_pkg::f_is_nan(i_a)) begin
            n_s1.sp = '{1'b1, i_a | 32'h00400000};
        end else if (mm4f_pkg::f_is_nan(i_b)) begin
            n_s1.sp = '{1'b1, i_b | 32'h00400000};
        end else if (mm4f_pkg::f_is_inf(i_a)) begin
            if (mm4f_pkg::f_is_inf(i_b) && sa != sb) begin
                n_s1.sp = '{1'b1, mm4f_pkg::DEFAULT_NAN};
            end else begin
                n_s1.sp = '{1'b1, i_a};
            end
        end else if (mm4f_pkg::f_is_inf(i_b)) begin
            n_s1.sp = '{1'b1, i_b};
        end
        if (ea < eb) begin
            {ma, mb} = {mb, ma};
            {ea, eb} = {eb, ea};
            {sa, sb} = {sb, sa};
        end
        d = ea - eb;
        // Two guard bits above a sticky position suffice for rounding.
        full = {mb, 26'd0};
        if (d >= 8'd27) begin
            shf = {26'd0, |mb, 23'd0};
        end else begin
            shf = full >> d;
            shf[23] = shf[23] | (|shf[22:0]);
        end
        n_s1.sa     = sa;
        n_s1.sb     = sb;
        n_s1.ea     = {2'd0, ea};
        n_s1.big    = {ma, 3'd0};
        n_s1.lesser = {shf[49:24], shf[23]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    // Signed magnitude add.
    always_comb begin
        logic [27:0] r;
        n_s2 = '0;
        n_s2.sp = r_s1.sp;
        if (r_s1.sa == r_s1.sb) begin
            r = {1'b0, r_s1.big} + {1'b0, r_s1.lesser};
            n_s2.sign = r_s1.sa;
        end else if (r_s1.big >= r_s1.lesser) begin
            r = {1'b0, r_s1.big - r_s1.lesser};
            n_s2.sign = r_s1.sa;
        end else begin
            r = {1'b0, r_s1.lesser - r_s1.big};
            n_s2.sign = r_s1.sb;
        end
        n_s2.zero = (r == 28'd0);
        if (n_s2.zero) begin
            n_s2.sign = r_s1.sa & r_s1.sb;
        end
        n_s2.mant = {22'd0, r};
        n_s2.exp  = 11'(r_s1.ea) - 11'd3;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2 <= n_s2;
        end
    end

    // Normalize and round.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_s2.sp.hit) begin
                o_s <= r_s2.sp.value;
            end else if (r_s2.zero) begin
                o_s <= {r_s2.sign, 31'd0};
            end else begin
                o_s <= mm4f_pkg::f_round(r_s2.sign, r_s2.mant, 12'(signed'(r_s2.exp)),
                                         mm4f_pkg::f_lead(r_s2.mant));
            end
        end
    end

endmodule

FILE: test/tb_matrix4x4_float_multiply.sv
`timescale 1ns / 1ps

module tb_matrix4x4_float_multiply;

    localparam int NUM_RANDOM = 1350;
    localparam int LATENCY    = 9;

    // One input word as the driver presents it.
    typedef struct {
        logic        opcode;
        logic [1:0]  row;
        logic [31:0] elem [4];
    } t_word;

    // One product row as the monitor expects it.
    typedef struct {
        logic [1:0]  row;
        logic [31:0] prod [4];
    } t_prod_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_opcode;
    logic [1:0]  i_row;
    logic [31:0] i_elem_a;
    logic [31:0] i_elem_b;
    logic [31:0] i_elem_c;
    logic [31:0] i_elem_d;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_out_row;
    logic [31:0] o_prod_a;
    logic [31:0] o_prod_b;
    logic [31:0] o_prod_c;
    logic [31:0] o_prod_d;

    t_word       pending_words [$];
    t_prod_row   expected_rows [$];
    logic [31:0] right_rows [4][4];
    int          error_count = 0;
    bit          quiet_tail;
    bit          hold_go;
    bit          hold_on;
    int          send_gap;
    int          recv_gap;
    logic        o_ready_seen;

    matrix4x4_float_multiply DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_opcode  (i_opcode),
        .i_row     (i_row),
        .i_elem_a  (i_elem_a),
        .i_elem_b  (i_elem_b),
        .i_elem_c  (i_elem_c),
        .i_elem_d  (i_elem_d),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_out_row (o_out_row),
        .o_prod_a  (o_prod_a),
        .o_prod_b  (o_prod_b),
        .o_prod_c  (o_prod_c),
        .o_prod_d  (o_prod_d)
    );

    // Clock with a 4 ns period.
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic bit fp_nan(logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    function automatic bit fp_inf(logic [31:0] a);
        return a[30:0] == 31'h7F800000;
    endfunction

    // Value is m * 2^(e - 150).
    function automatic void fp_split(logic [31:0] a, output logic [63:0] m, output int e);
        if (a[30:23] == 8'd0) begin
            m = {41'd0, a[22:0]};
            e = 1;
        end else begin
            m = {40'd0, 1'b1, a[22:0]};
            e = int'(a[30:23]);
        end
    endfunction

    // Shift right with round to nearest even; a non-positive shift goes left.
    function automatic logic [63:0] shift_round(logic [63:0] m, int s);
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        if (s <= 0) return m << (-s);
        if (s >= 63) return 64'd0;
        q    = m >> s;
        rem  = m & ((64'd1 << s) - 64'd1);
        half = 64'd1 << (s - 1);
        if (rem > half || (rem == half && q[0])) q = q + 64'd1;
        return q;
    endfunction

    // Round sign * m * 2^x to binary32.
    function automatic logic [31:0] fp_pack(logic sign, logic [63:0] m, int x);
        int          p;
        int          e;
        logic [63:0] bits;
        p = 63;
        while (p > 0 && !m[p]) p--;
        e = p + x + 127;
        if (e >= 1) begin
            bits = (64'(e - 1) << 23) + shift_round(m, p - 23);
            if (bits >= 64'h7F800000) bits = 64'h7F800000;
        end else begin
            bits = shift_round(m, -(x + 149));
        end
        return {sign, bits[30:0]};
    endfunction

    function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
        logic        sign;
        logic [63:0] ma;
        logic [63:0] mb;
        int          ea;
        int          eb;
        sign = a[31] ^ b[31];
        if (fp_nan(a)) return a | 32'h00400000;
        if (fp_nan(b)) return b | 32'h00400000;
        if (fp_inf(a) || fp_inf(b)) begin
            if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return mm4f_pkg::DEFAULT_NAN;
            return {sign, mm4f_pkg::POS_INF[30:0]};
        end
        fp_split(a, ma, ea);
        fp_split(b, mb, eb);
        if (ma == 64'd0 || mb == 64'd0) return {sign, 31'd0};
        return fp_pack(sign, ma * mb, ea + eb - 300);
    endfunction

    function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
        logic        sa;
        logic        sb;
        logic        sr;
        logic        ts;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] tm;
        logic [63:0] big;
        logic [63:0] lesser;
        logic [63:0] full;
        logic [63:0] r;
        int          ea;
        int          eb;
        int          te;
        int          d;
        sa = a[31];
        sb = b[31];
        if (fp_nan(a)) return a | 32'h00400000;
        if (fp_nan(b)) return b | 32'h00400000;
        if (fp_inf(a)) begin
            if (fp_inf(b) && sa != sb) return mm4f_pkg::DEFAULT_NAN;
            return a;
        end
        if (fp_inf(b)) return b;
        fp_split(a, ma, ea);
        fp_split(b, mb, eb);
        if (ea < eb) begin
            tm = ma; te = ea; ts = sa;
            ma = mb; ea = eb; sa = sb;
            mb = tm; eb = te; sb = ts;
        end
        d    = ea - eb;
        big  = ma << 32;
        full = mb << 32;
        if (d >= 57) begin
            lesser = (mb != 64'd0) ? 64'd1 : 64'd0;
        end else begin
            lesser = full >> d;
            if ((full & ((64'd1 << d) - 64'd1)) != 64'd0) lesser[0] = 1'b1;
        end
        if (sa == sb) begin
            r = big + lesser;
            sr = sa;
        end else if (big >= lesser) begin
            r = big - lesser;
            sr = sa;
        end else begin
            r = lesser - big;
            sr = sb;
        end
        if (r == 64'd0) return {sa & sb, 31'd0};
        return fp_pack(sr, r, ea - 182);
    endfunction

    // Track the right-hand matrix and compute the product row of a multiply word.
    function automatic void predict_word(t_word w);
        t_prod_row   pr;
        logic [31:0] s01;
        logic [31:0] s23;
        if (w.opcode == mm4f_pkg::OP_LOAD) begin
            for (int j = 0; j < 4; j++) right_rows[w.row][j] = w.elem[j];
            return;
        end
        pr.row = w.row;
        for (int j = 0; j < 4; j++) begin
            s01 = fp_add(fp_mul(w.elem[0], right_rows[0][j]),
                         fp_mul(w.elem[1], right_rows[1][j]));
            s23 = fp_add(fp_mul(w.elem[2], right_rows[2][j]),
                         fp_mul(w.elem[3], right_rows[3][j]));
            pr.prod[j] = fp_add(s01, s23);
        end
        expected_rows.push_back(pr);
    endfunction

    // Element patterns weighted toward the floating-point corner cases.
    function automatic logic [31:0] pick_elem();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 15))
            0:  v = {v[31], 31'd0};
            1:  v = {v[31], mm4f_pkg::POS_INF[30:0]};
            2:  v = {v[31], 8'hFF, v[22:0] | 23'd1};
            3:  v = {v[31], 8'd0, v[22:0]};
            4:  v = {v[31], 8'hFE, v[22:0]};
            5:  v = {v[31], 8'(126 + $urandom_range(0, 2)), v[22:0]};
            6:  v = {v[31], 8'(1 + $urandom_range(0, 2)), v[22:0]};
            default: v = {v[31], 8'(100 + $urandom_range(0, 54)), v[22:0]};
        endcase
        return v;
    endfunction

    function automatic t_word make_word(logic op, logic [1:0] row, logic [31:0] a,
                                        logic [31:0] b, logic [31:0] c, logic [31:0] d);
        t_word w;
        w.opcode = op;
        w.row    = row;
        w.elem[0] = a;
        w.elem[1] = b;
        w.elem[2] = c;
        w.elem[3] = d;
        return w;
    endfunction

    // Driver: presents queued words at the falling edge, with random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            i_opcode <= mm4f_pkg::OP_LOAD;
            i_row    <= 2'd0;
            i_elem_a <= 32'd0;
            i_elem_b <= 32'd0;
            i_elem_c <= 32'd0;
            i_elem_d <= 32'd0;
            send_gap <= 0;
        end else if (i_valid && !o_ready_seen) begin
            // Hold the current word until it is accepted.
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            i_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
            if (!quiet_tail && $urandom_range(0, 19) == 0) begin
                send_gap <= $urandom_range(0, 14);
                i_valid <= 1'b0;
            end else begin
                t_word w;
                w = pending_words.pop_front();
                predict_word(w);
                i_valid  <= 1'b1;
                i_opcode <= w.opcode;
                i_row    <= w.row;
                i_elem_a <= w.elem[0];
                i_elem_b <= w.elem[1];
                i_elem_c <= w.elem[2];
                i_elem_d <= w.elem[3];
            end
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Whether the word on the bus was taken at the last rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ready_seen <= 1'b1;
        end else begin
            o_ready_seen <= !(i_valid && !o_ready);
        end
    end

    // Long receiver hold-off, counted here while the driver keeps sending.
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (200) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    // Receiver ready: random bursts of back-pressure plus one long hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            recv_gap <= 0;
        end else if (hold_on) begin
            i_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            i_ready <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 19) == 0) begin
            recv_gap <= $urandom_range(0, 14);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Monitor: checks each accepted product row against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_rows.size() == 0) begin
                $error("unexpected product row %0d", o_out_row);
                error_count++;
            end else begin
                t_prod_row pr;
                logic [31:0] got [4];
                pr = expected_rows.pop_front();
                got[0] = o_prod_a;
                got[1] = o_prod_b;
                got[2] = o_prod_c;
                got[3] = o_prod_d;
                if (o_out_row !== pr.row) begin
                    $error("out_row: expected %0d, actual %0d", pr.row, o_out_row);
                    error_count++;
                end
                for (int j = 0; j < 4; j++) begin
                    if (got[j] !== pr.prod[j]) begin
                        $error("prod_%s: expected %08h, actual %08h",
                               j == 0 ? "a" : j == 1 ? "b" : j == 2 ? "c" : "d",
                               pr.prod[j], got[j]);
                        error_count++;
                    end
                end
            end
        end
    end

    // Run limit.
    initial begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

    // Stimulus and end of run.
    initial begin
        logic [31:0] e [4];
        logic [31:0] extremes [8];
        int          n;
        int          wait_cycles;
        extremes = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000,
                     32'h7FC00001, 32'h00000001, 32'h7F7FFFFF, 32'hFFFFFFFF};
        quiet_tail = 1'b0;
        hold_go    = 1'b0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: load an identity-like matrix, then corner-case rows.
        for (int r = 0; r < 4; r++) begin
            pending_words.push_back(make_word(mm4f_pkg::OP_LOAD, 2'(r),
                r == 0 ? 32'h3F800000 : 32'h00000000, r == 1 ? 32'h3F800000 : 32'h0,
                r == 2 ? 32'h3F800000 : 32'h0, r == 3 ? 32'h3F800000 : 32'h0));
        end
        for (int k = 0; k < 8; k++) begin
            pending_words.push_back(make_word(mm4f_pkg::OP_MUL, 2'(k), extremes[k],
                extremes[(k + 1) % 8], extremes[(k + 2) % 8], extremes[(k + 5) % 8]));
        end
        // Infinities of opposite sign summed, huge products that overflow.
        pending_words.push_back(make_word(mm4f_pkg::OP_LOAD, 2'd0, 32'h7F800000,
                                          32'h7F7FFFFF, 32'h00000001, 32'h80000000));
        pending_words.push_back(make_word(mm4f_pkg::OP_LOAD, 2'd1, 32'hFF800000,
                                          32'h7F7FFFFF, 32'h00800000, 32'h80000000));
        pending_words.push_back(make_word(mm4f_pkg::OP_MUL, 2'd3, 32'h3F800000,
                                          32'h3F800000, 32'h80000000, 32'h80000000));
        pending_words.push_back(make_word(mm4f_pkg::OP_MUL, 2'd2, 32'h7F7FFFFF,
                                          32'h7F7FFFFF, 32'h00000000, 32'hFFFFFFFF));
        pending_words.push_back(make_word(mm4f_pkg::OP_MUL, 2'd1, 32'hBF800000,
                                          32'h3F800000, 32'h3F000000, 32'h3F000000));

        // Random: mostly multiplies, with loads refreshing rows in random order.
        n = 0;
        while (n < NUM_RANDOM) begin
            for (int j = 0; j < 4; j++) e[j] = ($urandom_range(0, 3) == 0) ?
                                                $urandom : pick_elem();
            pending_words.push_back(make_word($urandom_range(0, 3) == 0 ?
                                              mm4f_pkg::OP_LOAD : mm4f_pkg::OP_MUL,
                                              2'($urandom_range(0, 3)),
                                              e[0], e[1], e[2], e[3]));
            n++;
            if (n == NUM_RANDOM / 3) begin
                // Long receiver hold-off while words keep arriving.
                while (pending_words.size() > 40) @(posedge i_clk);
                hold_go = 1'b1;
            end
            if (n == (NUM_RANDOM * 4) / 5) begin
                while (pending_words.size() > 0) @(posedge i_clk);
                quiet_tail = 1'b1;
            end
        end

        while (pending_words.size() > 0 || (i_valid && !o_ready_seen)) @(posedge i_clk);
        wait_cycles = 0;
        while (expected_rows.size() > 0 && wait_cycles < 10000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (LATENCY * 4) @(posedge i_clk);
        if (expected_rows.size() > 0) begin
            $error("%0d product rows never arrived", expected_rows.size());
        end
        if (error_count == 0 && expected_rows.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/mm4f_pkg.sv
rtl/core/mm4f_fmul.sv
rtl/core/mm4f_fadd.sv
rtl/core/matrix4x4_float_multiply.sv
test/tb_matrix4x4_float_multiply.sv
